>>> rtl/retb_pkg.sv
// Shared types, codes and constants for the reloading event timer bank.
package retb_pkg;

  // Default number of timers in the bank.
  localparam int TIMER_COUNT_DEF = 4;

  // Depth of the command queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  // Divide by ten: floor(x / 10) == (x * RECIP_10) >> DIV_SHIFT for any 32-bit x.
  localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;
  localparam int DIV_SHIFT = 35;

  // Request codes as they arrive on the input channel.
  typedef enum logic [2:0] {
    REQ_TICK       = 3'd0,
    REQ_SET_PERIOD = 3'd1,
    REQ_CLEAR_FLAG = 3'd2,
    REQ_READ_FLAG  = 3'd3,
    REQ_READ_TIME  = 3'd4
  } req_code_t;

  // Operations after classification by the front part.
  typedef enum logic [2:0] {
    OP_TICK,
    OP_SET,
    OP_CLEAR,
    OP_READ_FLAG,
    OP_READ_TIME,
    OP_NONE
  } op_t;

  // Back part sequencer states.
  typedef enum logic [1:0] {
    BS_IDLE,
    BS_TICK,
    BS_DIV
  } back_state_t;

  // Input item.
  typedef struct packed {
    logic [2:0]  req_type;
    logic [1:0]  timer_id;
    logic [15:0] period;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic        flag_value;
    logic [28:0] time_tenths;
  } out_item_t;

  // Classified command held in the queue.
  typedef struct packed {
    op_t         op;
    logic        in_bank;
    logic [1:0]  timer_id;
    logic [15:0] period;
  } cmd_t;

  // Queue status seen by the front part.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> rtl/retb_front.sv
// Front part: accepts items and classifies them into commands.
module retb_front
  import retb_pkg::*;
#(
  parameter int TIMER_COUNT = TIMER_COUNT_DEF
) (
  input  logic      in_valid,
  input  in_item_t  in_data,
  output logic      in_stall,
  input  q_status_t q_status,
  output logic      push,
  output cmd_t      cmd
);

  localparam logic [4:0] COUNT5 = 5'(TIMER_COUNT);

  // The queue takes an item whenever it has room.
  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  // Decode the request and check the timer address against the bank size.
  always_comb begin
    cmd.in_bank  = ({3'b000, in_data.timer_id} < COUNT5);
    cmd.timer_id = in_data.timer_id;
    cmd.period   = in_data.period;
    case (in_data.req_type)
      REQ_TICK:       cmd.op = OP_TICK;
      REQ_SET_PERIOD: cmd.op = OP_SET;
      REQ_CLEAR_FLAG: cmd.op = OP_CLEAR;
      REQ_READ_FLAG:  cmd.op = OP_READ_FLAG;
      REQ_READ_TIME:  cmd.op = OP_READ_TIME;
      default:        cmd.op = OP_NONE;
    endcase
  end

endmodule

>>> rtl/retb_queue.sv
// Short command queue between the front and back parts.
module retb_queue
  import retb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cmd_t             push_cmd,
  input  logic             pop,
  output cmd_t             head_cmd,
  output q_status_t        status,
  output logic [LVL_W-1:0] level
);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(QUEUE_DEPTH);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;

  assign status.full  = (level_r == LVL_FULL);
  assign status.empty = (level_r == '0);
  assign level        = level_r;
  assign head_cmd     = slot_r[rd_ptr_r];

  // Pointer and fill level updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (pop && !push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> rtl/retb_back.sv
// Back part: timer state, shared decrementer, divide by ten and result register.
module retb_back
  import retb_pkg::*;
#(
  parameter int TIMER_COUNT = TIMER_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  input  logic      q_empty,
  output logic      pop,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_stall
);

  localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TIMER_COUNT - 1);

  back_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] tick_idx_r, tick_idx_nxt;
  logic [15:0]      down_r [TIMER_COUNT];
  logic [15:0]      down_nxt [TIMER_COUNT];
  logic [15:0]      period_r [TIMER_COUNT];
  logic [15:0]      period_nxt [TIMER_COUNT];
  logic             flag_r [TIMER_COUNT];
  logic             flag_nxt [TIMER_COUNT];
  logic [31:0]      tick_total_r, tick_total_nxt;
  logic [63:0]      prod_r, prod_nxt;
  logic             res_valid_r, res_valid_nxt;
  out_item_t        res_r, res_nxt;
  logic [IDX_W+1:0] id_wide;
  logic [IDX_W-1:0] cmd_idx;
  logic             slot_free;

  assign out_valid = res_valid_r;
  assign out_data  = res_r;

  // Timer index from the two-bit address; only used when in the bank.
  assign id_wide   = {{IDX_W{1'b0}}, cmd.timer_id};
  assign cmd_idx   = id_wide[IDX_W-1:0];
  assign slot_free = !res_valid_r || !out_stall;

  // Sequencer: one command at a time, ticks walk the timers one per cycle.
  always_comb begin
    state_nxt      = state_r;
    tick_idx_nxt   = tick_idx_r;
    down_nxt       = down_r;
    period_nxt     = period_r;
    flag_nxt       = flag_r;
    tick_total_nxt = tick_total_r;
    prod_nxt       = prod_r;
    res_valid_nxt  = res_valid_r;
    res_nxt        = res_r;
    pop            = 1'b0;
    if (res_valid_r && !out_stall) begin
      res_valid_nxt = 1'b0;
    end
    case (state_r)
      BS_IDLE: begin
        if (!q_empty && slot_free) begin
          pop     = 1'b1;
          res_nxt = '0;
          case (cmd.op)
            OP_TICK: begin
              tick_idx_nxt = '0;
              state_nxt    = BS_TICK;
            end
            OP_SET: begin
              if (cmd.in_bank) begin
                down_nxt[cmd_idx]   = cmd.period;
                period_nxt[cmd_idx] = cmd.period;
                flag_nxt[cmd_idx]   = 1'b0;
              end
              res_valid_nxt = 1'b1;
            end
            OP_CLEAR: begin
              if (cmd.in_bank) begin
                flag_nxt[cmd_idx] = 1'b0;
              end
              res_valid_nxt = 1'b1;
            end
            OP_READ_FLAG: begin
              res_nxt.flag_value = cmd.in_bank && flag_r[cmd_idx];
              res_valid_nxt      = 1'b1;
            end
            OP_READ_TIME: begin
              prod_nxt  = {32'd0, tick_total_r} * {32'd0, RECIP_10};
              state_nxt = BS_DIV;
            end
            default: begin
              res_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      BS_TICK: begin
        // Shared decrementer serves the timer under the walk index.
        if (down_r[tick_idx_r] != 16'd0) begin
          down_nxt[tick_idx_r] = down_r[tick_idx_r] - 16'd1;
        end else begin
          down_nxt[tick_idx_r] = period_r[tick_idx_r];
          flag_nxt[tick_idx_r] = 1'b1;
        end
        if (tick_idx_r == IDX_LAST) begin
          tick_total_nxt = tick_total_r + 32'd1;
          res_nxt        = '0;
          res_valid_nxt  = 1'b1;
          state_nxt      = BS_IDLE;
        end else begin
          tick_idx_nxt = tick_idx_r + 1'b1;
        end
      end
      BS_DIV: begin
        // Product was registered last cycle; the quotient is its upper bits.
        res_nxt.flag_value  = 1'b0;
        res_nxt.time_tenths = prod_r[DIV_SHIFT+28:DIV_SHIFT];
        res_valid_nxt       = 1'b1;
        state_nxt           = BS_IDLE;
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase
  end

  // Control and timer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BS_IDLE;
      tick_idx_r   <= '0;
      tick_total_r <= '0;
      res_valid_r  <= 1'b0;
      for (int i = 0; i < TIMER_COUNT; i++) begin
        down_r[i]   <= '0;
        period_r[i] <= '0;
        flag_r[i]   <= 1'b0;
      end
    end else begin
      state_r      <= state_nxt;
      tick_idx_r   <= tick_idx_nxt;
      tick_total_r <= tick_total_nxt;
      res_valid_r  <= res_valid_nxt;
      down_r       <= down_nxt;
      period_r     <= period_nxt;
      flag_r       <= flag_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
  end

endmodule

>>> rtl/reloading_event_timer_bank_top.sv
// Top level of the reloading event timer bank.
// A bank of TIMER_COUNT periodic down-counting timers plus a 32-bit tick
// counter. Every request gives exactly one result. Requests enter a
// two-entry queue and are carried out one at a time by the back part: a
// tick walks the timers one per cycle through one shared decrementer;
// read time uses a registered 32x32 multiply by the reciprocal of ten;
// set period, clear flag, read flag and unknown requests are done in the
// idle state. The back part starts the next request only once the result
// register is empty or is being taken in that cycle; while a result waits
// for the receiver the queue takes up to two more items and then stalls
// the input.
module reloading_event_timer_bank_top
  import retb_pkg::*;
#(
  parameter int TIMER_COUNT = TIMER_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_item_t  in_data,
  output logic      in_stall,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_stall
);

  q_status_t        q_status;
  logic             push;
  logic             pop;
  cmd_t             push_cmd;
  cmd_t             head_cmd;
  logic [LVL_W-1:0] q_level;

  // Accept and classify.
  retb_front #(
    .TIMER_COUNT(TIMER_COUNT)
  ) u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_status (q_status),
    .push     (push),
    .cmd      (push_cmd)
  );

  // Decoupling queue.
  retb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .status   (q_status),
    .level    (q_level)
  );

  // Execute.
  retb_back #(
    .TIMER_COUNT(TIMER_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (head_cmd),
    .q_empty   (q_status.empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  // The queue never holds more than its depth.
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= LVL_W'(QUEUE_DEPTH))
    else $error("queue level above depth");

  // Nothing is popped from an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

  // A result never carries both a flag and a time.
  a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.flag_value && (out_data.time_tenths != '0)))
    else $error("result carries both flag and time");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule
